### rtl/npd_pkg.sv
`default_nettype none

package npd_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_OBJ    = 8;
  localparam int COORD_W    = 24;

  localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PIDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int OBJ_W   = (MAX_OBJ > 1) ? $clog2(MAX_OBJ) : 1;
  localparam int ADDR_W  = PIDX_W + OBJ_W;
  localparam int DEPTH   = MAX_POINTS * (2 ** OBJ_W);

  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int ACC_W   = SQ_W + OBJ_W;
  localparam int ROOT_W  = (ACC_W + 1) / 2;

  localparam int CFG_OBJ_W  = 4;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int OP_W       = 2;
  localparam int DIST_W     = 26;
  localparam int IN_DATA_W  = ((COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DIST_W + 1 + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_OBJ   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXCL_ZERO = 1'd1;

  localparam logic [CFG_OBJ_W-1:0] NUM_OBJ_RESET = 4'd2;

endpackage

`default_nettype wire

### rtl/npd_ram.sv
`default_nettype none

module npd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/npd_sqrt.sv
`default_nettype none

module npd_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [npd_pkg::ACC_W-1:0]  radicand,
  output logic                            done,
  output logic      [npd_pkg::ROOT_W-1:0] root
);

  localparam int X_W   = 2 * npd_pkg::ROOT_W;
  localparam int REM_W = npd_pkg::ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int CNT_W = (npd_pkg::ROOT_W > 1) ? $clog2(npd_pkg::ROOT_W) : 1;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [X_W-1:0]   x;
  logic [REM_W-1:0] rem;
  logic [SH_W-1:0]  rem_sh;
  logic [SH_W-1:0]  trial;
  logic [SH_W-1:0]  diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem, x[X_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    ge     = (rem_sh >= trial);
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == '0) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= CNT_W'(npd_pkg::ROOT_W - 1);
      x    <= X_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      cnt  <= cnt - 1'b1;
      x    <= {x[X_W-3:0], 2'b00};
      rem  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[npd_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/nearest_point_distance.sv
`default_nettype none

// channel  dir  tdata                                    tuser
// s_axis   in   coordinate [23:0]                        opcode [1:0]
// m_axis   out  min_distance [25:0], points_dropped [26] status [0]
// cfg      in   cfg_index 0 num_objectives, 1 exclude_zero, cfg_data [3:0]
//
// load and clear requests leave the block idle and ready for the next request
// a completing query reads the front once per stored coordinate, runs a five
// stage distance pipeline, then the one-bit-per-cycle square root; the root
// is skipped when no point qualifies, and an empty front skips the scan too
// rst is synchronous; the front memory needs no clearing pass
// s_axis_tready is low while a query runs or its result waits for a free
// output register

module nearest_point_distance (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [npd_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // coordinate
  input  wire logic [npd_pkg::OP_W-1:0]           s_axis_tuser,  // opcode
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [npd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // min_distance, points_dropped
  output logic      [0:0]                         m_axis_tuser,  // status
  input  wire logic                               cfg_wr_en,
  input  wire logic [npd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [npd_pkg::CFG_W-1:0]          cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int PCNT_W = npd_pkg::PCNT_W;
  localparam int PIDX_W = npd_pkg::PIDX_W;
  localparam int OBJ_W  = npd_pkg::OBJ_W;
  localparam int NW     = npd_pkg::CFG_OBJ_W;
  localparam int CW     = npd_pkg::COORD_W;
  localparam int DW     = npd_pkg::DIST_W;
  localparam int RW     = npd_pkg::ROOT_W;
  localparam int ACC_W  = npd_pkg::ACC_W;
  localparam int CMP_W  = RW + DW;

  typedef struct packed {
    logic first;
    logic last;
    logic last_pt;
  } tag_t;

  logic [1:0]          st;
  logic [NW-1:0]       num_obj;
  logic                excl;
  logic [NW-1:0]       n_eff;
  logic [PCNT_W-1:0]   pc;
  logic [OBJ_W-1:0]    lidx;
  logic [OBJ_W-1:0]    qidx;
  logic                ovf;
  logic [CW-1:0]       qbuf [npd_pkg::MAX_OBJ];

  logic                in_acc;
  logic [npd_pkg::OP_W-1:0] op;
  logic [CW-1:0]       coord;
  logic                load_last;
  logic                query_last;
  logic                front_full;

  logic                issuing;
  logic [PIDX_W-1:0]   ip;
  logic [OBJ_W-1:0]    ij;
  tag_t                tag_iss;

  logic                v0, v1, v2, v3, done4;
  tag_t                tag0, tag1, tag2;
  logic [OBJ_W-1:0]    j0;
  logic [CW-1:0]       ram_rdata;
  logic signed [npd_pkg::DIFF_W-1:0] d;
  logic [npd_pkg::DIFF_W-1:0]        d_abs;
  logic [CW-1:0]       mag1;
  logic [npd_pkg::SQ_W-1:0] sq2;
  logic [ACC_W-1:0]    acc3;
  logic                lastp3;
  logic [ACC_W-1:0]    best;
  logic                found;
  logic                better;

  logic                sqrt_start;
  logic                sqrt_done;
  logic [RW-1:0]       sqrt_root;
  logic [DW-1:0]       root_sat;

  logic                ram_we;
  logic                emit_go;
  logic [DW-1:0]       out_dist;
  logic                out_dropped;
  logic                out_status;

  assign op    = s_axis_tuser;
  assign coord = s_axis_tdata[CW-1:0];

  assign s_axis_tready = (st == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (num_obj == '0) begin
      n_eff = NW'(1);
    end else if (num_obj > NW'(npd_pkg::MAX_OBJ)) begin
      n_eff = NW'(npd_pkg::MAX_OBJ);
    end else begin
      n_eff = num_obj;
    end
  end

  assign front_full = (pc == PCNT_W'(npd_pkg::MAX_POINTS));
  assign load_last  = (NW'(lidx) + NW'(1)) >= n_eff;
  assign query_last = (NW'(qidx) + NW'(1)) >= n_eff;
  assign ram_we     = in_acc && (op == npd_pkg::OP_LOAD) && !front_full;

  assign tag_iss.first   = (ij == '0);
  assign tag_iss.last    = (NW'(ij) + NW'(1)) >= n_eff;
  assign tag_iss.last_pt = (PCNT_W'(ip) + PCNT_W'(1)) == pc;

  npd_ram #(
    .WIDTH (CW),
    .DEPTH (npd_pkg::DEPTH)
  ) u_front (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr ({pc[PIDX_W-1:0], lidx}),
    .wr_data (coord),
    .rd_addr ({ip, ij}),
    .rd_data (ram_rdata)
  );

  // distance datapath
  always_comb begin
    d     = $signed({qbuf[j0][CW-1], qbuf[j0]}) - $signed({ram_rdata[CW-1], ram_rdata});
    d_abs = d[npd_pkg::DIFF_W-1] ? npd_pkg::DIFF_W'(-d) : npd_pkg::DIFF_W'(d);
    better = !(excl && acc3 == '0) && (!found || acc3 < best);
  end

  always_comb begin
    if (CMP_W'(sqrt_root) > CMP_W'({DW{1'b1}})) begin
      root_sat = {DW{1'b1}};
    end else begin
      root_sat = DW'(sqrt_root);
    end
  end

  assign emit_go = (st == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  npd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (best),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      num_obj       <= npd_pkg::NUM_OBJ_RESET;
      excl          <= 1'b0;
      pc            <= '0;
      lidx          <= '0;
      qidx          <= '0;
      ovf           <= 1'b0;
      issuing       <= 1'b0;
      ip            <= '0;
      ij            <= '0;
      v0            <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      done4         <= 1'b0;
      found         <= 1'b0;
      sqrt_start    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          npd_pkg::REG_NUM_OBJ:   num_obj <= cfg_data[NW-1:0];
          npd_pkg::REG_EXCL_ZERO: excl    <= cfg_data[0];
          default: ;
        endcase
      end

      sqrt_start <= 1'b0;
      v0         <= issuing;
      v1         <= v0;
      v2         <= v1;
      v3         <= v2 && tag2.last;
      done4      <= v3 && lastp3;

      if (v3 && better) begin
        found <= 1'b1;
      end

      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (st)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (op)
              npd_pkg::OP_LOAD: begin
                if (front_full) begin
                  ovf <= 1'b1;
                end else if (load_last) begin
                  lidx <= '0;
                  pc   <= pc + 1'b1;
                end else begin
                  lidx <= lidx + 1'b1;
                end
              end
              npd_pkg::OP_QUERY: begin
                if (query_last) begin
                  qidx  <= '0;
                  found <= 1'b0;
                  ip    <= '0;
                  ij    <= '0;
                  if (pc == '0) begin
                    st <= ST_EMIT;
                  end else begin
                    st      <= ST_SCAN;
                    issuing <= 1'b1;
                  end
                end else begin
                  qidx <= qidx + 1'b1;
                end
              end
              npd_pkg::OP_CLEAR: begin
                pc   <= '0;
                lidx <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            if (tag_iss.last) begin
              ij <= '0;
              if (tag_iss.last_pt) begin
                issuing <= 1'b0;
              end else begin
                ip <= ip + 1'b1;
              end
            end else begin
              ij <= ij + 1'b1;
            end
          end
          if (done4) begin
            if (found) begin
              sqrt_start <= 1'b1;
              st         <= ST_ROOT;
            end else begin
              st <= ST_EMIT;
            end
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            st <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            m_axis_tvalid <= 1'b1;
            st            <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && op == npd_pkg::OP_QUERY) begin
      qbuf[qidx] <= coord;
    end
    tag0 <= tag_iss;
    j0   <= ij;
    tag1 <= tag0;
    mag1 <= d_abs[CW-1:0];
    tag2 <= tag1;
    sq2  <= mag1 * mag1;
    if (v2) begin
      acc3   <= (tag2.first ? '0 : acc3) + ACC_W'(sq2);
      lastp3 <= tag2.last_pt;
    end
    if (v3 && better) begin
      best <= acc3;
    end
    if (emit_go) begin
      out_dist    <= found ? root_sat : '0;
      out_status  <= !found;
      out_dropped <= ovf;
    end
  end

  assign m_axis_tdata = {{(npd_pkg::OUT_DATA_W - DW - 1){1'b0}}, out_dropped, out_dist};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

### rtl/npd_checker.sv
`default_nettype none

module npd_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [npd_pkg::OP_W-1:0]       s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [npd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]                     m_axis_tuser
);

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no point found means zero distance
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[npd_pkg::DIST_W-1:0] == '0)
    else $error("status set with non-zero distance");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result after reset");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == npd_pkg::OP_LOAD && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("result after load request");

endmodule

bind nearest_point_distance npd_checker u_npd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import npd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 600;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              no_match;
    logic              dropped;
  } distance_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // coordinate
  logic [OP_W-1:0]       s_axis_tuser;   // opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // min_distance, points_dropped
  logic [0:0]            m_axis_tuser;   // status
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // predicted block state
  logic signed [COORD_W-1:0] front_coord [MAX_POINTS][MAX_OBJ];
  logic signed [COORD_W-1:0] query_coord [MAX_OBJ];
  int                        front_points;
  int                        load_slot;
  int                        query_slot;
  logic                      dropped_sticky;
  logic [CFG_OBJ_W-1:0]      cfg_objectives;
  logic                      cfg_skip_zero;

  distance_result_t pending_distances [$];
  distance_result_t seen_result;
  distance_result_t wanted_result;
  int               fault_count = 0;
  logic             steady = 1'b0;
  int               hold_requests = 0;
  int               holds_served = 0;

  nearest_point_distance u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_objectives(input logic [CFG_OBJ_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > MAX_OBJ) return MAX_OBJ;
    return setting;
  endfunction

  function automatic longint unsigned squared_gap(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return $unsigned(d * d);
  endfunction

  function automatic logic [DIST_W-1:0] floor_root(input longint unsigned value);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return COORD_MIN;
    if (pick < 10) return COORD_MAX;
    if (pick < 40) return COORD_W'(int'($urandom_range(8192)) - 4096);
    return COORD_W'($urandom);
  endfunction

  function automatic logic signed [COORD_W-1:0] near_coord(
      input logic signed [COORD_W-1:0] base);
    if ($urandom_range(3) != 0) return base;
    return base + COORD_W'(int'($urandom_range(2)) - 1);
  endfunction

  task automatic predict_request(input logic [OP_W-1:0] op,
                                 input logic signed [COORD_W-1:0] coord);
    int n;
    logic found;
    longint unsigned best;
    longint unsigned acc;
    distance_result_t res;
    n = active_objectives(cfg_objectives);
    case (op)
      OP_LOAD: begin
        if (front_points >= MAX_POINTS) begin
          dropped_sticky = 1'b1;
        end else begin
          front_coord[front_points][load_slot] = coord;
          if (load_slot + 1 >= n) begin
            load_slot = 0;
            front_points++;
          end else begin
            load_slot++;
          end
        end
      end
      OP_CLEAR: begin
        front_points = 0;
        load_slot = 0;
      end
      OP_QUERY: begin
        query_coord[query_slot] = coord;
        if (query_slot + 1 < n) begin
          query_slot++;
        end else begin
          query_slot = 0;
          found = 1'b0;
          best = 0;
          for (int p = 0; p < front_points; p++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc += squared_gap(query_coord[j], front_coord[p][j]);
            if (!(cfg_skip_zero && acc == 0) && (!found || acc < best)) begin
              best = acc;
              found = 1'b1;
            end
          end
          res.distance = found ? floor_root(best) : '0;
          res.no_match = !found;
          res.dropped  = dropped_sticky;
          pending_distances = {pending_distances, res};
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [COORD_W-1:0] coord);
    int gap;
    gap = (!steady && $urandom_range(99) < 21) ? $urandom_range(4, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= coord;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(op, coord);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (index == REG_NUM_OBJ) cfg_objectives = value[CFG_OBJ_W-1:0];
    else cfg_skip_zero = value[0];
  endtask

  task automatic set_mode(input logic [CFG_OBJ_W-1:0] objectives, input logic skip_zero);
    logic grows;
    drain_results();
    grows = active_objectives(objectives) > active_objectives(cfg_objectives);
    write_register(REG_NUM_OBJ, objectives);
    write_register(REG_EXCL_ZERO, {{(CFG_W-1){1'b0}}, skip_zero});
    // stored points are shorter than the new count
    if (grows && front_points != 0) send_request(OP_CLEAR, random_coord());
  endtask

  task automatic report_fault(input string what, input distance_result_t want,
                              input distance_result_t got);
    if (fault_count < 10)
      $display("%s: expected distance %0d status %0d dropped %0d, got %0d %0d %0d",
               what, want.distance, want.no_match, want.dropped,
               got.distance, got.no_match, got.dropped);
    fault_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_result.distance = m_axis_tdata[DIST_W-1:0];
      seen_result.dropped  = m_axis_tdata[DIST_W];
      seen_result.no_match = m_axis_tuser[0];
      if (pending_distances.size() == 0) begin
        report_fault("result with no request behind it", '0, seen_result);
      end else begin
        wanted_result = pending_distances.pop_front();
        if (seen_result !== wanted_result)
          report_fault("distance mismatch", wanted_result, seen_result);
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 21);
      end
    end
  end

  task automatic test_empty_front();
    send_request(OP_QUERY, '0);
    send_request(OP_QUERY, '0);
    send_request(OP_LOAD, 24'sd4096);
    send_request(OP_LOAD, -24'sd8192);
    send_request(OP_QUERY, 24'sd4096);
    send_request(OP_QUERY, -24'sd8192);
  endtask

  task automatic test_coordinate_extremes();
    set_mode(4'd0, 1'b0);
    send_request(OP_CLEAR, '0);
    send_request(OP_LOAD, COORD_MIN);
    send_request(OP_QUERY, COORD_MAX);
  endtask

  task automatic test_skip_zero();
    set_mode(4'd1, 1'b1);
    send_request(OP_CLEAR, '0);
    send_request(OP_LOAD, 24'sd4096);
    send_request(OP_LOAD, 24'sd12288);
    send_request(OP_QUERY, 24'sd4096);
    send_request(OP_CLEAR, '0);
    send_request(OP_LOAD, -24'sd4096);
    send_request(OP_QUERY, -24'sd4096);
  endtask

  task automatic test_count_change();
    set_mode(4'd15, 1'b0);
    send_request(OP_CLEAR, '0);
    repeat (3) send_request(OP_LOAD, random_coord());
    repeat (3) send_request(OP_QUERY, random_coord());
    // point and query both finish early under the smaller count
    set_mode(4'd2, 1'b0);
    send_request(OP_LOAD, random_coord());
    send_request(OP_QUERY, random_coord());
  endtask

  task automatic test_unused_opcode();
    send_request(OP_UNUSED, random_coord());
    send_request(OP_QUERY, random_coord());
    // clear keeps the query position
    send_request(OP_CLEAR, random_coord());
    send_request(OP_LOAD, random_coord());
    send_request(OP_LOAD, random_coord());
    send_request(OP_QUERY, random_coord());
  endtask

  task automatic test_receiver_backpressure();
    set_mode(4'd1, 1'b0);
    send_request(OP_CLEAR, '0);
    repeat (4) send_request(OP_LOAD, random_coord());
    steady = 1'b1;
    hold_requests++;
    repeat (10) send_request(OP_QUERY, random_coord());
    drain_results();
    steady = 1'b0;
  endtask

  task automatic run_random_phase(input int budget, input int front_cap);
    int sent;
    int pick;
    int n;
    int target;
    logic [OP_W-1:0] op;
    sent = 0;
    while (sent < budget) begin
      n = active_objectives(cfg_objectives);
      pick = $urandom_range(99);
      if (pick < 8) begin
        op = OP_W'($urandom_range(3));
        send_request(op, random_coord());
        if (op != OP_UNUSED) sent++;
      end else if (pick < 14 || (pick < 45 && front_points >= front_cap)) begin
        send_request(OP_CLEAR, random_coord());
        sent++;
      end else if (pick < 45) begin
        for (int j = 0; j < n; j++) send_request(OP_LOAD, random_coord());
        sent += n;
      end else begin
        target = (front_points != 0 && $urandom_range(1) == 1) ?
                 $urandom_range(front_points - 1) : -1;
        for (int j = 0; j < n; j++) begin
          if (target < 0) send_request(OP_QUERY, random_coord());
          else send_request(OP_QUERY, near_coord(front_coord[target][j]));
        end
        sent += n;
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [CFG_OBJ_W-1:0] objectives;
    for (int phase = 0; phase < 20; phase++) begin
      case (phase)
        0: objectives = 4'd1;
        1: objectives = 4'd8;
        2: objectives = 4'd0;
        3: objectives = 4'd15;
        4: objectives = 4'd2;
        5: objectives = 4'd3;
        default: objectives = CFG_OBJ_W'($urandom_range(15));
      endcase
      set_mode(objectives, (phase < 4) ? phase[0] : 1'($urandom_range(1)));
      steady = (phase == 5);
      run_random_phase(45, (phase % 7 == 6) ? 64 : 12);
      steady = 1'b0;
    end
  endtask

  task automatic test_front_overflow();
    set_mode(4'd2, 1'b0);
    send_request(OP_CLEAR, '0);
    repeat (MAX_POINTS * 2) send_request(OP_LOAD, random_coord());
    repeat (2) send_request(OP_QUERY, random_coord());
    repeat (3) send_request(OP_LOAD, random_coord());
    repeat (2) send_request(OP_QUERY, random_coord());
    // the dropped flag survives a clear
    send_request(OP_CLEAR, '0);
    repeat (2) send_request(OP_LOAD, random_coord());
    repeat (2) send_request(OP_QUERY, random_coord());
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_LOAD;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_NUM_OBJ;
    cfg_data       = '0;
    front_points   = 0;
    load_slot      = 0;
    query_slot     = 0;
    dropped_sticky = 1'b0;
    cfg_objectives = NUM_OBJ_RESET;
    cfg_skip_zero  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_front();
    test_coordinate_extremes();
    test_skip_zero();
    test_count_change();
    test_unused_opcode();
    test_receiver_backpressure();
    test_random_traffic();
    test_front_overflow();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(100_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
